[sv/fifo_free_list_index_allocator_defines.svh]
// assertion macros used by the allocator datapath
`ifndef FIFO_FREE_LIST_INDEX_ALLOCATOR_DEFINES_SVH
`define FIFO_FREE_LIST_INDEX_ALLOCATOR_DEFINES_SVH

// clocked check, skipped while reset is asserted
`define FFLA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked check, also checked during reset
`define FFLA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/ffla_pkg.sv]
// shared types and constants of the free list index allocator
package ffla_pkg;

    localparam int MAX_HANDLES = 1024;
    localparam int HANDLE_W    = 11;
    localparam int SLOT_W      = $clog2(MAX_HANDLES);

    localparam logic [HANDLE_W-1:0] NUM_HANDLES = HANDLE_W'(MAX_HANDLES);
    localparam logic [SLOT_W-1:0]   LAST_SLOT   = SLOT_W'(MAX_HANDLES - 1);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic exec;
    } t_cmd;

endpackage

[sv/ffla_ram.sv]
// generic single write port ram with registered read
module ffla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/ffla_ctrl.sv]
// controller state machine of the allocator
module ffla_ctrl
    import ffla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_EXEC;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_READ: o_cmd.rd   = 1'b1;
            ST_EXEC: o_cmd.exec = 1'b1;
            default: busy       = 1'b1;
        endcase
    end

endmodule

[sv/ffla_dp.sv]
// datapath of the allocator: queue, marks, pointers and counts
module ffla_dp
    import ffla_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic                i_action,
    input  logic [HANDLE_W-1:0] i_handle_in,
    output logic                o_strobe,
    output logic [HANDLE_W-1:0] o_granted_handle,
    output logic                o_free_accepted,
    output logic [HANDLE_W-1:0] o_in_use_count
);

`include "fifo_free_list_index_allocator_defines.svh"

    logic                r_action;
    logic [HANDLE_W-1:0] r_handle;
    logic [SLOT_W-1:0]   r_head;
    logic [SLOT_W-1:0]   r_tail;
    logic                r_head_wrap;
    logic                r_tail_wrap;
    logic [HANDLE_W-1:0] r_used;
    logic                r_valid;
    logic [HANDLE_W-1:0] r_granted;
    logic                r_accepted;

    logic [SLOT_W-1:0]   n_head;
    logic [SLOT_W-1:0]   n_tail;
    logic                n_head_wrap;
    logic                n_tail_wrap;
    logic [HANDLE_W-1:0] n_used;
    logic [HANDLE_W-1:0] n_granted;
    logic                n_accepted;

    logic [HANDLE_W-1:0] q_rdata;
    logic                q_we;
    logic [0:0]          m_rdata;
    logic                m_we;
    logic [SLOT_W-1:0]   m_waddr;
    logic [0:0]          m_wdata;

    logic                slot_written;
    logic [HANDLE_W-1:0] head_handle;
    logic                mark_known;
    logic                mark_set;
    logic                in_range;

    // unwritten queue slots are read as their slot index plus one
    assign slot_written = r_tail_wrap || (r_head < r_tail);
    assign head_handle  = slot_written ? q_rdata : HANDLE_W'(r_head) + HANDLE_W'(1);
    // a handle never granted yet has a clear mark
    assign mark_known   = r_head_wrap || (r_handle <= HANDLE_W'(r_head));
    assign mark_set     = mark_known && m_rdata[0];
    assign in_range     = (r_handle != '0) && (r_handle <= NUM_HANDLES);

    ffla_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (MAX_HANDLES)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_tail),
        .i_wdata (r_handle),
        .i_re    (i_cmd.rd),
        .i_raddr (r_head),
        .o_rdata (q_rdata)
    );

    ffla_ram #(
        .WIDTH (1),
        .DEPTH (MAX_HANDLES)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (SLOT_W'(r_handle - HANDLE_W'(1))),
        .o_rdata (m_rdata)
    );

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_head_wrap = r_head_wrap;
        n_tail_wrap = r_tail_wrap;
        n_used      = r_used;
        n_granted   = '0;
        n_accepted  = 1'b0;
        q_we        = 1'b0;
        m_we        = 1'b0;
        m_waddr     = SLOT_W'(r_handle - HANDLE_W'(1));
        m_wdata     = 1'b0;
        if (i_cmd.exec) begin
            if (r_action == ACT_ALLOC) begin
                if (r_used != NUM_HANDLES) begin
                    n_granted = head_handle;
                    m_we      = 1'b1;
                    m_waddr   = SLOT_W'(head_handle - HANDLE_W'(1));
                    m_wdata   = 1'b1;
                    n_used    = r_used + HANDLE_W'(1);
                    if (r_head == LAST_SLOT) begin
                        n_head      = '0;
                        n_head_wrap = 1'b1;
                    end else begin
                        n_head = r_head + SLOT_W'(1);
                    end
                end
            end else begin
                if (in_range && mark_set) begin
                    n_accepted = 1'b1;
                    m_we       = 1'b1;
                    q_we       = 1'b1;
                    n_used     = r_used - HANDLE_W'(1);
                    if (r_tail == LAST_SLOT) begin
                        n_tail      = '0;
                        n_tail_wrap = 1'b1;
                    end else begin
                        n_tail = r_tail + SLOT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_head_wrap <= 1'b0;
            r_tail_wrap <= 1'b0;
            r_used      <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_head_wrap <= n_head_wrap;
            r_tail_wrap <= n_tail_wrap;
            r_used      <= n_used;
            r_valid     <= i_cmd.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_handle <= i_handle_in;
        end
        if (i_cmd.exec) begin
            r_granted  <= n_granted;
            r_accepted <= n_accepted;
        end
    end

    assign o_strobe         = r_valid;
    assign o_granted_handle = r_granted;
    assign o_free_accepted  = r_accepted;
    assign o_in_use_count   = r_used;

    `FFLA_ASSERT(a_used_bound, i_clk, i_rst_n, r_used <= NUM_HANDLES, "in-use count above range")
    `FFLA_ASSERT(a_one_kind, i_clk, i_rst_n, r_valid |-> !(r_accepted && (r_granted != '0)), "grant and free in one result")
    `FFLA_ASSERT(a_grant_range, i_clk, i_rst_n, r_valid |-> (r_granted <= NUM_HANDLES), "granted handle out of range")
    `FFLA_ASSERT(a_count_step, i_clk, i_rst_n, !i_cmd.exec |=> $stable(r_used), "count moved without a request")
    `FFLA_ASSERT_ALWAYS(a_single_strobe, i_clk, r_valid |=> !r_valid, "result strobe longer than one cycle")

endmodule

[sv/fifo_free_list_index_allocator.sv]
// top level of the fifo free list index allocator
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------------------------
//  request  | start / busy     | i_action, i_handle_in
//  result   | o_strobe         | o_granted_handle, o_free_accepted, o_in_use_count
//
// each request passes through register, queue and mark ram read, and update;
// the result strobe is registered from the update and shows when busy is already low again
// the single read and write port of each ram sets these steps
// reset is synchronous and needs no clearing pass: untouched queue slots and
// marks are decoded from the head and tail pointers
// results cannot be stalled; each is shown for exactly one cycle
module fifo_free_list_index_allocator
    import ffla_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_action,
    input  logic [HANDLE_W-1:0] i_handle_in,
    output logic                o_strobe,
    output logic [HANDLE_W-1:0] o_granted_handle,
    output logic                o_free_accepted,
    output logic [HANDLE_W-1:0] o_in_use_count
);

    t_cmd cmd;

    ffla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    ffla_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_action         (i_action),
        .i_handle_in      (i_handle_in),
        .o_strobe         (o_strobe),
        .o_granted_handle (o_granted_handle),
        .o_free_accepted  (o_free_accepted),
        .o_in_use_count   (o_in_use_count)
    );

endmodule

[test/tb_fifo_free_list_index_allocator.sv]
// self-checking testbench of the fifo free list index allocator
module tb_fifo_free_list_index_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import ffla_pkg::*;

    typedef struct packed {
        logic [HANDLE_W-1:0] granted;
        logic                accepted;
        logic [HANDLE_W-1:0] in_use;
    } t_alloc_result;

    typedef struct packed {
        logic                action;
        logic [HANDLE_W-1:0] handle;
        bit                  fixed;
        t_alloc_result       result;
    } t_directed_row;

    localparam int NUM_DIRECTED = 18;
    localparam int HANDLE_SPAN  = (1 << HANDLE_W) - 1;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                i_action    = ACT_ALLOC;
    logic [HANDLE_W-1:0] i_handle_in = '0;
    logic                busy;
    logic                o_strobe;
    logic [HANDLE_W-1:0] o_granted_handle;
    logic                o_free_accepted;
    logic [HANDLE_W-1:0] o_in_use_count;

    // free handle ring, in-use marks and count as the block should hold them
    logic [HANDLE_W-1:0] ring [MAX_HANDLES];
    int                  ring_head;
    int                  ring_tail;
    int                  ring_fill;
    bit                  marks [MAX_HANDLES+1];
    int                  in_use_total;

    t_alloc_result       pending_results [$];
    logic [HANDLE_W-1:0] handles_out [$];
    logic [HANDLE_W-1:0] last_freed = '0;
    bit                  idle_on = 1'b1;
    int                  mismatch_count = 0;

    t_directed_row directed_rows [NUM_DIRECTED] = '{
        '{ACT_ALLOC, 11'd0,    1'b1, '{11'd1, 1'b0, 11'd1}},
        '{ACT_ALLOC, 11'd2047, 1'b1, '{11'd2, 1'b0, 11'd2}},
        '{ACT_FREE,  11'd0,    1'b1, '{11'd0, 1'b0, 11'd2}},
        '{ACT_FREE,  11'd2047, 1'b1, '{11'd0, 1'b0, 11'd2}},
        '{ACT_FREE,  11'd1025, 1'b1, '{11'd0, 1'b0, 11'd2}},
        '{ACT_FREE,  11'd1024, 1'b1, '{11'd0, 1'b0, 11'd2}},
        '{ACT_FREE,  11'd3,    1'b1, '{11'd0, 1'b0, 11'd2}},
        '{ACT_FREE,  11'd1,    1'b1, '{11'd0, 1'b1, 11'd1}},
        '{ACT_FREE,  11'd1,    1'b1, '{11'd0, 1'b0, 11'd1}},
        '{ACT_ALLOC, 11'd1365, 1'b1, '{11'd3, 1'b0, 11'd2}},
        '{ACT_FREE,  11'd2,    1'b1, '{11'd0, 1'b1, 11'd1}},
        '{ACT_ALLOC, 11'd682,  1'b0, '{11'd0, 1'b0, 11'd0}},
        '{ACT_FREE,  11'd1026, 1'b1, '{11'd0, 1'b0, 11'd2}},
        '{ACT_FREE,  11'd1365, 1'b1, '{11'd0, 1'b0, 11'd2}},
        '{ACT_FREE,  11'd682,  1'b1, '{11'd0, 1'b0, 11'd2}},
        '{ACT_FREE,  11'd4,    1'b0, '{11'd0, 1'b0, 11'd0}},
        '{ACT_FREE,  11'd3,    1'b0, '{11'd0, 1'b0, 11'd0}},
        '{ACT_ALLOC, 11'd0,    1'b0, '{11'd0, 1'b0, 11'd0}}
    };

    fifo_free_list_index_allocator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_handle_in      (i_handle_in),
        .o_strobe         (o_strobe),
        .o_granted_handle (o_granted_handle),
        .o_free_accepted  (o_free_accepted),
        .o_in_use_count   (o_in_use_count)
    );

    always #1ns i_clk = ~i_clk;

    function automatic void allocator_clear();
        for (int i = 0; i < MAX_HANDLES; i++) begin
            ring[i] = HANDLE_W'(i + 1);
        end
        for (int i = 0; i <= MAX_HANDLES; i++) begin
            marks[i] = 1'b0;
        end
        ring_head    = 0;
        ring_tail    = 0;
        ring_fill    = MAX_HANDLES;
        in_use_total = 0;
    endfunction

    function automatic t_alloc_result allocator_predict(logic act, logic [HANDLE_W-1:0] h);
        t_alloc_result r;
        r = '0;
        if (act == ACT_ALLOC) begin
            if (ring_fill != 0) begin
                r.granted = ring[ring_head];
                ring_head = (ring_head == MAX_HANDLES - 1) ? 0 : ring_head + 1;
                ring_fill--;
                marks[r.granted] = 1'b1;
                in_use_total++;
            end
        end else if (h >= 1 && h <= MAX_HANDLES && marks[h]) begin
            marks[h]        = 1'b0;
            ring[ring_tail] = h;
            ring_tail       = (ring_tail == MAX_HANDLES - 1) ? 0 : ring_tail + 1;
            ring_fill++;
            if (in_use_total != 0) begin
                in_use_total--;
            end
            r.accepted = 1'b1;
        end
        r.in_use = HANDLE_W'(in_use_total);
        return r;
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_free_handle();
        if (handles_out.size() != 0 && $urandom_range(0, 99) < 85) begin
            return handles_out[$urandom_range(0, handles_out.size() - 1)];
        end else if ($urandom_range(0, 1) == 1) begin
            return last_freed;
        end
        return HANDLE_W'($urandom_range(0, HANDLE_SPAN));
    endfunction

    task automatic issue_request(input logic act, input logic [HANDLE_W-1:0] h,
                                 input bit fixed, input t_alloc_result typed);
        t_alloc_result predicted;
        if (idle_on && $urandom_range(0, 99) < 10) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_action    <= act;
        i_handle_in <= h;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        predicted = allocator_predict(act, h);
        pending_results.push_back(fixed ? typed : predicted);
        if (predicted.granted != 0) begin
            handles_out.push_back(predicted.granted);
        end
        if (predicted.accepted) begin
            last_freed = h;
            for (int i = 0; i < handles_out.size(); i++) begin
                if (handles_out[i] == h) begin
                    handles_out.delete(i);
                    break;
                end
            end
        end
    endtask

    task automatic random_request(input int alloc_pct);
        if ($urandom_range(0, 99) < alloc_pct) begin
            issue_request(ACT_ALLOC, HANDLE_W'($urandom_range(0, HANDLE_SPAN)), 1'b0, '0);
        end else begin
            issue_request(ACT_FREE, pick_free_handle(), 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request pending: %h %b %h", $time,
                         o_granted_handle, o_free_accepted, o_in_use_count);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_granted_handle !== want.granted) begin
                    $display("%0t: granted_handle expected %0d actual %0d", $time,
                             want.granted, o_granted_handle);
                    mismatch_count++;
                end
                if (o_free_accepted !== want.accepted) begin
                    $display("%0t: free_accepted expected %0b actual %0b", $time,
                             want.accepted, o_free_accepted);
                    mismatch_count++;
                end
                if (o_in_use_count !== want.in_use) begin
                    $display("%0t: in_use_count expected %0d actual %0d", $time,
                             want.in_use, o_in_use_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        allocator_clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            issue_request(directed_rows[i].action, directed_rows[i].handle,
                          directed_rows[i].fixed, directed_rows[i].result);
        end

        repeat (100) random_request(50);

        // fill the pool back to back so the head pointer wraps
        idle_on = 1'b0;
        while (ring_fill != 0) random_request(96);
        idle_on = 1'b1;

        // allocate against an empty pool and reuse freed slots after the wrap
        repeat (40) random_request(70);

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("fifo_free_list_index_allocator regression: pass");
        end else begin
            $display("fifo_free_list_index_allocator regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("fifo_free_list_index_allocator regression: fail");
        $finish;
    end

endmodule
